@@ rtl/tod_pkg.sv @@
`default_nettype none

package tod_pkg;

    localparam int OP_W    = 3;
    localparam int IDX_W   = 16;
    localparam int DEV_W   = 8;
    localparam int EPOCH_W = 32;
    localparam int COUNT_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY    = 3'd0,
        OP_TRANSFER = 3'd1,
        OP_PREFETCH = 3'd2,
        OP_COMPLETE = 3'd3,
        OP_BARRIER  = 3'd4
    } t_op;

endpackage

`default_nettype wire

@@ rtl/tod_channels.sv @@
`default_nettype none

interface tod_req_if;
    logic                       valid;
    logic                       ready;
    logic [tod_pkg::OP_W-1:0]   operation;
    logic [tod_pkg::IDX_W-1:0]  tensor_index;
    logic [tod_pkg::DEV_W-1:0]  device;

    modport source (output valid, output operation, output tensor_index, output device,
                    input ready);
    modport sink   (input valid, input operation, input tensor_index, input device,
                    output ready);
endinterface

interface tod_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [tod_pkg::DEV_W-1:0]    owner_now;
    logic                         pending_now;
    logic [tod_pkg::EPOCH_W-1:0]  epoch_now;

    modport source (output valid, output status, output owner_now, output pending_now,
                    output epoch_now, input ready);
    modport sink   (input valid, input status, input owner_now, input pending_now,
                    input epoch_now, output ready);
endinterface

interface tod_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tod_pkg::COUNT_W-1:0]  tensor_count;

    modport source (output valid, output tensor_count, input ready);
    modport sink   (input valid, input tensor_count, output ready);
endinterface

`default_nettype wire

@@ rtl/tensor_ownership_directory.sv @@
// channel   dir   modport  payload
// i_req     in    sink     operation, tensor_index, device
// o_rsp     out   source   status, owner_now, pending_now, epoch_now
// i_cfg     in    sink     tensor_count (always ready out of reset)
//
// one request per cycle while the response is not stalled; each goes through the
// registered ram read, then the read-modify-write and the response register.
// after reset the owner/pending ram is swept to zero, one entry a cycle, so
// requests are held off until the sweep ends; i_cfg is taken meanwhile.
// a stalled response holds the working stage, which then holds i_req.
`default_nettype none

module tensor_ownership_directory #(
    parameter int MAX_TENSORS = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tod_req_if.sink   i_req,
    tod_rsp_if.source o_rsp,
    tod_cfg_if.sink   i_cfg
);

    localparam int AW = (MAX_TENSORS > 1) ? $clog2(MAX_TENSORS) : 1;
    localparam int DW = tod_pkg::DEV_W;
    localparam int IW = tod_pkg::IDX_W;
    localparam logic [AW-1:0]  LAST_ADDR = AW'(MAX_TENSORS - 1);
    localparam logic [IW:0]    MAX_CNT   = (IW + 1)'(MAX_TENSORS);

    // configuration
    logic [tod_pkg::COUNT_W-1:0] r_tensor_count;

    // clearing sweep
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // working stage
    logic                        r_s1_valid;
    logic [tod_pkg::OP_W-1:0]    r_s1_op;
    logic [IW-1:0]               r_s1_idx;
    logic [DW-1:0]               r_s1_dev;
    logic                        r_s1_inr;
    logic                        r_fwd_st;
    logic [DW:0]                 r_fwd_st_data;
    logic                        r_fwd_tg;
    logic [DW-1:0]               r_fwd_tg_data;

    logic [tod_pkg::EPOCH_W-1:0] r_epoch;

    // response register
    logic                        r_out_valid;
    logic                        r_out_status;
    logic [DW-1:0]               r_out_owner;
    logic                        r_out_pend;
    logic [tod_pkg::EPOCH_W-1:0] r_out_epoch;

    logic [IW:0]   count_ext;
    logic [IW:0]   count_eff;
    logic          in_range;
    logic          in_fire;
    logic          s1_adv;

    logic [DW:0]   st_rdata;
    logic [DW-1:0] tg_rdata;
    logic [DW:0]   cur_st;
    logic [DW-1:0] cur_tg;

    logic          st_we;
    logic          tg_we;
    logic          n_pend;
    logic [DW-1:0] n_owner;
    logic          n_status;
    logic [tod_pkg::EPOCH_W-1:0] n_epoch;

    logic          ram_st_we;
    logic [AW-1:0] ram_st_waddr;
    logic [DW:0]   ram_st_wdata;

    assign count_ext = (IW + 1)'(r_tensor_count);
    assign count_eff = (count_ext > MAX_CNT) ? MAX_CNT : count_ext;
    assign in_range  = {1'b0, i_req.tensor_index} < count_eff;

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = i_rst_n && !r_clearing && (!r_s1_valid || s1_adv);
    assign in_fire     = i_req.valid && i_req.ready;
    assign i_cfg.ready = i_rst_n;

    // a write retiring in the same cycle as the read is not seen by the ram
    assign cur_st = r_fwd_st ? r_fwd_st_data : st_rdata;
    assign cur_tg = r_fwd_tg ? r_fwd_tg_data : tg_rdata;

    always_comb begin
        st_we    = 1'b0;
        tg_we    = 1'b0;
        n_owner  = cur_st[DW-1:0];
        n_pend   = cur_st[DW];
        n_status = tod_pkg::STATUS_OK;
        n_epoch  = r_epoch;
        case (r_s1_op)
            tod_pkg::OP_QUERY: begin
                if (!r_s1_inr) begin
                    n_status = tod_pkg::STATUS_ERR;
                end
            end
            tod_pkg::OP_TRANSFER: begin
                if (r_s1_inr) begin
                    n_owner = r_s1_dev;
                    st_we   = 1'b1;
                end else begin
                    n_status = tod_pkg::STATUS_ERR;
                end
            end
            tod_pkg::OP_PREFETCH: begin
                if (r_s1_inr) begin
                    n_pend = 1'b1;
                    st_we  = 1'b1;
                    tg_we  = 1'b1;
                end else begin
                    n_status = tod_pkg::STATUS_ERR;
                end
            end
            tod_pkg::OP_COMPLETE: begin
                if (r_s1_inr && cur_st[DW]) begin
                    n_owner = cur_tg;
                    n_pend  = 1'b0;
                    st_we   = 1'b1;
                end else begin
                    n_status = tod_pkg::STATUS_ERR;
                end
            end
            tod_pkg::OP_BARRIER: begin
                n_epoch = r_epoch + 1'b1;
            end
            default: begin
                n_status = tod_pkg::STATUS_ERR;
            end
        endcase
    end

    assign ram_st_we    = r_clearing || (s1_adv && st_we);
    assign ram_st_waddr = r_clearing ? r_clr_addr : r_s1_idx[AW-1:0];
    assign ram_st_wdata = r_clearing ? '0 : {n_pend, n_owner};

    tod_ram #(
        .WIDTH (DW + 1),
        .DEPTH (MAX_TENSORS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_st_we),
        .i_waddr (ram_st_waddr),
        .i_wdata (ram_st_wdata),
        .i_re    (in_fire),
        .i_raddr (i_req.tensor_index[AW-1:0]),
        .o_rdata (st_rdata)
    );

    tod_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TENSORS)
    ) u_target_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv && tg_we),
        .i_waddr (r_s1_idx[AW-1:0]),
        .i_wdata (r_s1_dev),
        .i_re    (in_fire),
        .i_raddr (i_req.tensor_index[AW-1:0]),
        .o_rdata (tg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tensor_count <= tod_pkg::COUNT_RESET;
            r_clearing     <= 1'b1;
            r_clr_addr     <= '0;
            r_s1_valid     <= 1'b0;
            r_fwd_st       <= 1'b0;
            r_fwd_tg       <= 1'b0;
            r_epoch        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_tensor_count <= i_cfg.tensor_count;
            end

            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end

            if (in_fire) begin
                r_s1_valid    <= 1'b1;
                r_s1_op       <= i_req.operation;
                r_s1_idx      <= i_req.tensor_index;
                r_s1_dev      <= i_req.device;
                r_s1_inr      <= in_range;
                r_fwd_st      <= s1_adv && st_we && (r_s1_idx == i_req.tensor_index);
                r_fwd_st_data <= {n_pend, n_owner};
                r_fwd_tg      <= s1_adv && tg_we && (r_s1_idx == i_req.tensor_index);
                r_fwd_tg_data <= r_s1_dev;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
                r_fwd_st   <= 1'b0;
                r_fwd_tg   <= 1'b0;
            end

            if (s1_adv) begin
                r_epoch      <= n_epoch;
                r_out_valid  <= 1'b1;
                r_out_status <= n_status;
                r_out_owner  <= r_s1_inr ? n_owner : '0;
                r_out_pend   <= r_s1_inr ? n_pend : 1'b0;
                r_out_epoch  <= n_epoch;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = i_rst_n && r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.owner_now   = r_out_owner;
    assign o_rsp.pending_now = r_out_pend;
    assign o_rsp.epoch_now   = r_out_epoch;

`ifndef SYNTHESIS
    a_barrier_bumps_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_op == tod_pkg::OP_BARRIER) |=> (r_epoch == $past(r_epoch) + 1'b1))
        else $error("barrier did not advance the epoch");

    a_epoch_only_on_barrier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_adv && r_s1_op == tod_pkg::OP_BARRIER) |=> $stable(r_epoch))
        else $error("epoch moved without a barrier");

    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid && !r_out_valid)
        else $error("transaction in flight during the clearing sweep");

    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd_st || r_fwd_tg) |-> r_s1_valid)
        else $error("forwarding flag set with an empty working stage");
`endif

endmodule

`default_nettype wire

@@ rtl/tod_ram.sv @@
`default_nettype none

module tod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
